/* sv/rrms_pkg.sv */
package rrms_pkg;

    // List geometry
    localparam int MAX_MEMBERS = 16;
    localparam int CNT_W       = $clog2(MAX_MEMBERS + 1);
    localparam int IDX_W       = $clog2(MAX_MEMBERS);

    // Request modes
    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_PICK   = 2'd2;

    // Response status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DUP  = 2'd1;
    localparam logic [1:0] ST_NONE = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] peer_id;
        logic [31:0] member_ref;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] chosen_id;
        logic [31:0] chosen_ref;
    } t_rsp;

    // One list entry
    typedef struct packed {
        logic [15:0] id;
        logic [31:0] ref_val;
    } t_entry;

    // Command broadcast to every cell
    typedef struct packed {
        logic [15:0] id;
        logic [31:0] ref_val;
        logic        add_en;
        logic        rem_en;
    } t_cell_cmd;

    // Per-cell position flags
    typedef struct packed {
        logic valid;
        logic tail;
    } t_cell_ctl;

endpackage

/* sv/rrms_cell.sv */
module rrms_cell (
    input  logic               i_clk,
    input  rrms_pkg::t_cell_cmd i_cmd,
    input  rrms_pkg::t_cell_ctl i_ctl,
    input  logic               i_shift,
    input  rrms_pkg::t_entry   i_next,
    output logic               o_shift,
    output logic               o_match,
    output rrms_pkg::t_entry   o_entry
);
    import rrms_pkg::*;

    t_entry r_entry;

    // Compare the held id against the request
    assign o_match = i_ctl.valid && (r_entry.id == i_cmd.id);

    // Pass the shift request down the chain from the matching cell on
    assign o_shift = i_shift | o_match;
    assign o_entry = r_entry;

    // Pull the neighbor's entry on remove, take the new member at the tail on add
    always_ff @(posedge i_clk) begin
        if (i_cmd.rem_en && o_shift) begin
            r_entry <= i_next;
        end else if (i_cmd.add_en && i_ctl.tail) begin
            r_entry.id      <= i_cmd.id;
            r_entry.ref_val <= i_cmd.ref_val;
        end
    end

endmodule

/* sv/round_robin_member_selector.sv */
// A request beat is captured into the request register; its execute cycle then writes the result
// beat into the output register. Only one request is held: a new one is accepted once the held
// one has executed. The cell row compares, shifts and appends in the execute cycle.
// A waiting result stalls the execute cycle until it is taken.
// Reset (synchronous, active low) empties the list and zeroes the turn pointer;
// stored ids and handles are not cleared.
module round_robin_member_selector (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  rrms_pkg::t_req i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output rrms_pkg::t_rsp o_out
);
    import rrms_pkg::*;

    logic                   r_busy;
    t_req                   r_req;
    logic [CNT_W-1:0]       r_count;
    logic [IDX_W-1:0]       r_ptr;
    logic                   r_out_valid;
    t_rsp                   r_out;

    logic [CNT_W-1:0]       n_count;
    logic [IDX_W-1:0]       n_ptr;
    t_rsp                   n_out;

    logic                   w_exec;
    logic [MAX_MEMBERS-1:0] w_match;
    logic [MAX_MEMBERS:0]   w_shift;
    t_entry                 w_entry [MAX_MEMBERS];
    t_cell_cmd              w_cmd;
    logic                   w_found;
    logic                   w_full;
    logic                   w_before;
    logic                   w_at;
    logic [CNT_W-1:0]       w_cnt_dec;
    logic [IDX_W-1:0]       w_pick_pos;
    logic [CNT_W-1:0]       w_pick_inc;

    assign o_in_ready  = !r_busy;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Execute once the output register is free
    assign w_exec = r_busy && (!r_out_valid || i_out_ready);

    assign w_found   = |w_match;
    assign w_full    = (r_count == CNT_W'(MAX_MEMBERS));
    assign w_cnt_dec = r_count - 1'b1;

    // Broadcast the command to the row
    always_comb begin
        w_cmd.id      = r_req.peer_id;
        w_cmd.ref_val = r_req.member_ref;
        w_cmd.add_en  = w_exec && (r_req.mode == MODE_ADD) && !w_found && !w_full;
        w_cmd.rem_en  = w_exec && (r_req.mode == MODE_REMOVE) && w_found;
    end

    // Row of cells, entry k in cell k
    assign w_shift[0] = 1'b0;
    for (genvar k = 0; k < MAX_MEMBERS; k++) begin : g_cell
        t_cell_ctl w_ctl;
        t_entry    w_next;

        assign w_ctl.valid = (CNT_W'(k) < r_count);
        assign w_ctl.tail  = (CNT_W'(k) == r_count);

        if (k == MAX_MEMBERS - 1) begin : g_last
            assign w_next = w_entry[k];
        end else begin : g_mid
            assign w_next = w_entry[k+1];
        end

        rrms_cell u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_ctl   (w_ctl),
            .i_shift (w_shift[k]),
            .i_next  (w_next),
            .o_shift (w_shift[k+1]),
            .o_match (w_match[k]),
            .o_entry (w_entry[k])
        );
    end

    // Locate the removed member relative to the pointer
    assign w_before = (r_ptr != '0) && w_shift[r_ptr];
    assign w_at     = w_match[r_ptr];

    // Pick position and its successor
    assign w_pick_pos = (CNT_W'(r_ptr) < r_count) ? r_ptr : '0;
    assign w_pick_inc = CNT_W'(w_pick_pos) + 1'b1;

    // Next count, pointer and response
    always_comb begin
        n_count = r_count;
        n_ptr   = r_ptr;
        n_out   = '0;
        case (r_req.mode)
            MODE_ADD: begin
                if (w_found) begin
                    n_out.status = ST_DUP;
                end else if (w_full) begin
                    n_out.status = ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            MODE_REMOVE: begin
                if (!w_found) begin
                    n_out.status = ST_NONE;
                end else begin
                    n_count = w_cnt_dec;
                    if (w_before) begin
                        n_ptr = r_ptr - 1'b1;
                    end else if (w_at && (CNT_W'(r_ptr) == w_cnt_dec)) begin
                        n_ptr = '0;
                    end
                end
            end
            MODE_PICK: begin
                if (r_count == '0) begin
                    n_out.status = ST_NONE;
                end else begin
                    n_out.chosen_id  = w_entry[w_pick_pos].id;
                    n_out.chosen_ref = w_entry[w_pick_pos].ref_val;
                    n_ptr = (w_pick_inc == r_count) ? '0 : w_pick_inc[IDX_W-1:0];
                end
            end
            default: begin
                n_out.status = ST_OK;
            end
        endcase
    end

    // Hold control state, capture the request beat, drive the result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_count     <= '0;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_busy <= 1'b1;
            end else if (w_exec) begin
                r_busy <= 1'b0;
            end
            if (w_exec) begin
                r_count     <= n_count;
                r_ptr       <= n_ptr;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_req <= i_in;
        end
        if (w_exec) begin
            r_out <= n_out;
        end
    end

    // Count stays within the list depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_MEMBERS))
        else $error("member count exceeds list depth");

    // Pointer stays inside the live list
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 && r_ptr == '0) || (CNT_W'(r_ptr) < r_count))
        else $error("turn pointer outside live list");

    // Count changes only in an execute cycle
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_exec |=> $stable(r_count))
        else $error("member count changed without an execute cycle");

    // A failed request carries no member
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status != ST_OK)
            |-> (o_out.chosen_id == '0 && o_out.chosen_ref == '0))
        else $error("failed request returned a member");

endmodule
